[src/mfb_pkg.sv]
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants of the MAC frame builder.
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int AddrW    = 48;
    localparam int ApbAddrW = 4;
    localparam int ApbDataW = 64;
    localparam int LenW     = 12;

    // register map: one 64-bit register every 8 bytes, selected by paddr[3]
    localparam int RegSelBit = 3;
    localparam logic RegOwn   = 1'b0;
    localparam logic RegCoord = 1'b1;

    // input action codes
    typedef enum logic [1:0] {
        ACT_METRICS = 2'd0,
        ACT_CSMA    = 2'd1,
        ACT_TDMA    = 2'd2,
        ACT_RSVD    = 2'd3
    } t_action;

    // frame control words, sent low byte first
    localparam logic [15:0] FcProt = 16'h2900;
    localparam logic [15:0] FcMetr = 16'h2100;

    // byte position within a frame
    typedef logic [4:0] t_pos;
    localparam t_pos PosFirst   = 5'd0;
    localparam t_pos PosHdrLast = 5'd23;
    localparam t_pos PosPay     = 5'd24;
    localparam t_pos PosFcs0    = 5'd25;
    localparam t_pos PosFcsLast = 5'd28;

    localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
    localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out;

endpackage

[src/mfb_apb_regs.sv]
// ----------------------------------------------------------------------------
// mfb_apb_regs
// APB register file holding the own and coordinator MAC addresses.
// ----------------------------------------------------------------------------
module mfb_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfb_pkg::ApbAddrW-1:0]  paddr,
    input  logic [mfb_pkg::ApbDataW-1:0]  pwdata,
    output logic [mfb_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready,
    output logic [mfb_pkg::AddrW-1:0]     o_own_addr,
    output logic [mfb_pkg::AddrW-1:0]     o_coord_addr
);
    import mfb_pkg::*;

    logic             wr_en;
    logic [AddrW-1:0] r_own;
    logic [AddrW-1:0] r_coord;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own   <= '0;
            r_coord <= '0;
        end else if (wr_en) begin
            if (paddr[RegSelBit] == RegOwn) begin
                r_own <= pwdata[AddrW-1:0];
            end else begin
                r_coord <= pwdata[AddrW-1:0];
            end
        end
    end

    assign prdata = (paddr[RegSelBit] == RegCoord) ?
                    {{(ApbDataW-AddrW){1'b0}}, r_coord} :
                    {{(ApbDataW-AddrW){1'b0}}, r_own};

    assign o_own_addr   = r_own;
    assign o_coord_addr = r_coord;

endmodule

[src/mfb_crc.sv]
// ----------------------------------------------------------------------------
// mfb_crc
// Reflected CRC-32 register, one byte per cycle while enabled, restartable per frame.
// ----------------------------------------------------------------------------
module mfb_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_start,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);
    import mfb_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] n_crc;

    always_comb begin
        n_crc = (i_start ? CrcInit : r_crc) ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            n_crc = n_crc[0] ? ((n_crc >> 1) ^ CrcPoly) : (n_crc >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CrcInit;
        end else if (i_en) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

[src/mfb_out_buf.sv]
// ----------------------------------------------------------------------------
// mfb_out_buf
// Output register with skid entry; upstream ready is a registered flag.
// ----------------------------------------------------------------------------
module mfb_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  mfb_pkg::t_out       i_data,
    output logic                o_ready,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [7:0]          o_m_axis_tdata,
    output logic                o_m_axis_tlast
);
    import mfb_pkg::*;

    logic r_main_valid;
    logic r_skid_valid;
    t_out r_main;
    t_out r_skid;
    logic in_fire;
    logic out_fire;

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid & o_ready;
    assign out_fire = r_main_valid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_main_valid) begin
            r_main_valid <= r_skid_valid | in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_main_valid) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (in_fire) begin
            r_skid <= i_data;
        end
    end

    assign o_m_axis_tvalid = r_main_valid;
    assign o_m_axis_tdata  = r_main.data;
    assign o_m_axis_tlast  = r_main.last;

endmodule

[src/mac_frame_builder_crc32.sv]
// ----------------------------------------------------------------------------
// mac_frame_builder_crc32
// Throughput: one output byte per cycle while the sink is ready; a new item is
//   taken only as the held item's last byte leaves the output sequencer.
// Reset (sync, active low): addresses 0, CRC all ones, no message open.
// ----------------------------------------------------------------------------
module mac_frame_builder_crc32 #(
    parameter int MAX_PAYLOAD = 1500
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream: one item per transfer
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [23:0]                   i_s_axis_tdata,  // data_byte[7:0], message_length[19:8]
    input  logic [1:0]                    i_s_axis_tuser,  // action[1:0]
    input  logic                          i_s_axis_tlast,  // last item of the message
    // master stream: one frame byte per transfer
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // out_byte[7:0]
    output logic                          o_m_axis_tlast,  // final FCS byte
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfb_pkg::ApbAddrW-1:0]  paddr,
    input  logic [mfb_pkg::ApbDataW-1:0]  pwdata,
    output logic [mfb_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready
);
    import mfb_pkg::*;

    localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PAYLOAD);

    // ---------------- input fields ----------------
    t_action         in_action;
    logic [7:0]      in_byte;
    logic [LenW-1:0] in_len;
    logic            in_last;
    logic            in_fire;

    assign in_action = t_action'(i_s_axis_tuser);
    assign in_byte   = i_s_axis_tdata[7:0];
    assign in_len    = i_s_axis_tdata[19:8];
    assign in_last   = i_s_axis_tlast;
    assign in_fire   = i_s_axis_tvalid & o_s_axis_tready;

    // ---------------- configuration ----------------
    logic [AddrW-1:0] own_addr;
    logic [AddrW-1:0] coord_addr;

    mfb_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_own_addr   (own_addr),
        .o_coord_addr (coord_addr)
    );

    // ---------------- message state and item classification ----------------
    // Each accepted item is classified against the message state: does it
    // open a frame (header), carry a payload byte, close a frame (FCS)?
    // Items that produce nothing (dropped or empty mid-message) never
    // occupy the sequencer slot.
    logic       r_in_msg;
    logic       r_drop;
    logic       n_in_msg;
    logic       n_drop;
    logic       ld_hdr;
    logic       ld_prot;
    logic       ld_pay;
    logic       ld_fcs;
    logic [7:0] ld_byte;
    logic       ld_any;
    logic       is_prot;

    assign is_prot = (in_action == ACT_CSMA) || (in_action == ACT_TDMA);

    always_comb begin
        n_in_msg = r_in_msg;
        n_drop   = r_drop;
        ld_hdr   = 1'b0;
        ld_prot  = 1'b0;
        ld_pay   = 1'b0;
        ld_fcs   = 1'b0;
        ld_byte  = in_byte;
        if (!r_in_msg) begin
            if (is_prot) begin
                // protocol frame: complete in one item, last ignored
                ld_hdr  = 1'b1;
                ld_prot = 1'b1;
                ld_pay  = 1'b1;
                ld_fcs  = 1'b1;
                ld_byte = (in_action == ACT_TDMA) ? 8'h01 : 8'h00;
            end else if (in_len > MaxLen) begin
                // oversized metrics message: swallow up to its last item
                n_in_msg = !in_last;
                n_drop   = !in_last;
            end else begin
                ld_hdr   = 1'b1;
                ld_pay   = (in_len != '0);
                ld_fcs   = in_last;
                n_in_msg = !in_last;
                n_drop   = 1'b0;
            end
        end else if (r_drop) begin
            if (in_last) begin
                n_in_msg = 1'b0;
                n_drop   = 1'b0;
            end
        end else begin
            ld_pay = (in_len != '0);
            ld_fcs = in_last;
            if (in_last) begin
                n_in_msg = 1'b0;
            end
        end
    end

    assign ld_any = ld_hdr | ld_pay | ld_fcs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_drop   <= 1'b0;
        end else if (in_fire) begin
            r_in_msg <= n_in_msg;
            r_drop   <= n_drop;
        end
    end

    // ---------------- byte sequencer ----------------
    // One held item; r_pos walks header (0..23), payload (24), FCS (25..28),
    // skipping parts the item does not have. One byte leaves per cycle while the output buffer is ready.
    logic       r_busy;
    t_pos       r_pos;
    logic       r_prot;
    logic       r_pay;
    logic       r_fcs;
    logic [7:0] r_pay_byte;

    logic        buf_ready;
    logic        emit_fire;
    logic        emit_done;
    t_pos        pos_next;
    t_pos        pos_start;
    t_out        emit_data;
    logic [31:0] crc_val;
    logic [31:0] fcs_val;

    assign emit_fire       = r_busy & buf_ready;
    assign o_s_axis_tready = !r_busy || (emit_fire && emit_done);

    always_comb begin
        emit_done = 1'b0;
        pos_next  = r_pos + 5'd1;
        if (r_pos == PosHdrLast) begin
            pos_next  = r_pay ? PosPay : PosFcs0;
            emit_done = !r_pay && !r_fcs;
        end else if (r_pos == PosPay) begin
            emit_done = !r_fcs;
        end else if (r_pos == PosFcsLast) begin
            emit_done = 1'b1;
        end
    end

    assign pos_start = ld_hdr ? PosFirst : (ld_pay ? PosPay : PosFcs0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_fire && ld_any) begin
            r_busy <= 1'b1;
        end else if (emit_fire && emit_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && ld_any) begin
            r_pos      <= pos_start;
            r_prot     <= ld_prot;
            r_pay      <= ld_pay;
            r_fcs      <= ld_fcs;
            r_pay_byte <= ld_byte;
        end else if (emit_fire) begin
            r_pos <= pos_next;
        end
    end

    // address byte k of a MAC address, most significant byte first
    function automatic logic [7:0] addr_byte(input logic [AddrW-1:0] a,
                                             input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = a[47:40];
            3'd1:    b = a[39:32];
            3'd2:    b = a[31:24];
            3'd3:    b = a[23:16];
            3'd4:    b = a[15:8];
            default: b = a[7:0];
        endcase
        return b;
    endfunction

    assign fcs_val = ~crc_val;

    always_comb begin
        emit_data.last = (r_pos == PosFcsLast);
        case (r_pos)
            5'd0:  emit_data.data = r_prot ? FcProt[7:0]  : FcMetr[7:0];
            5'd1:  emit_data.data = r_prot ? FcProt[15:8] : FcMetr[15:8];
            5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9:
                emit_data.data = addr_byte(coord_addr, 3'(r_pos - 5'd4));
            5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
                emit_data.data = addr_byte(own_addr, 3'(r_pos - 5'd10));
            5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21:
                emit_data.data = addr_byte(coord_addr, 3'(r_pos - 5'd16));
            5'd24: emit_data.data = r_pay_byte;
            5'd25: emit_data.data = fcs_val[7:0];
            5'd26: emit_data.data = fcs_val[15:8];
            5'd27: emit_data.data = fcs_val[23:16];
            5'd28: emit_data.data = fcs_val[31:24];
            // duration, sequence control
            default: emit_data.data = 8'h00;
        endcase
    end

    // CRC covers header and payload; it restarts on the first header byte
    mfb_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (emit_fire && (r_pos <= PosPay)),
        .i_start (r_pos == PosFirst),
        .i_byte  (emit_data.data),
        .o_crc   (crc_val)
    );

    mfb_out_buf u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_busy),
        .i_data          (emit_data),
        .o_ready         (buf_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // ---------------- assertions ----------------
    a_drop_in_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> r_in_msg)
        else $error("dropping set outside a message");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !emit_fire) |=> (r_busy && $stable(r_pos)))
        else $error("sequencer moved without a transfer");

    a_hdr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && ld_hdr) |=> (r_busy && r_pos == PosFirst))
        else $error("frame start did not load header position");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos <= PosFcsLast))
        else $error("byte position out of range");

endmodule

[tb/tb_mac_frame_builder_crc32.sv]
// ----------------------------------------------------------------------------
// tb_mac_frame_builder_crc32
// Self-checking bench for the MAC frame builder: a queue-fed stream driver,
// a byte monitor, and an in-bench frame predictor (header, payload, CRC-32
// FCS). The run covers a directed corner sweep and then random message
// traffic under several address settings.
// ----------------------------------------------------------------------------
module tb_mac_frame_builder_crc32;

    timeunit 1ns;
    timeprecision 1ps;

    import mfb_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int MaxPayload   = 1500;  // matches the DUT default
    localparam int SettleCycles = 8;     // dropped items are silent
    localparam int HoldCycles   = 400;   // one long sink back-pressure window
    localparam int HoldAfter    = 800;   // bytes seen before that window opens
    localparam int IdleLimit    = 5000;  // watchdog: cycles with no transfer
    localparam int PhaseItems   = 80;    // random items per address setting

    // one input item as the stream carries it
    typedef struct {
        t_action          act;
        logic [7:0]       data;
        logic [LenW-1:0]  len;
        logic             fin;
    } t_item;

    // ------------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [23:0]          s_data  = '0;   // data_byte[7:0], message_length[19:8]
    logic [1:0]           s_user  = '0;   // action[1:0]
    logic                 s_last  = 1'b0; // last item of the message
    logic                 m_ready = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ApbAddrW-1:0]  paddr   = '0;
    logic [ApbDataW-1:0]  pwdata  = '0;

    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [7:0]           o_m_axis_tdata;
    logic                 o_m_axis_tlast;
    logic [ApbDataW-1:0]  prdata;
    logic                 pready;

    mac_frame_builder_crc32 #(
        .MAX_PAYLOAD (MaxPayload)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_item        pending_items[$];    // items waiting for the driver
    t_out         frame_bytes_due[$];  // predicted output bytes, oldest first
    t_item        cur_item;

    // predictor's copy of the block state and address registers
    logic [31:0]      run_crc   = CrcInit;
    logic             msg_open  = 1'b0;
    logic             msg_drop  = 1'b0;
    logic [AddrW-1:0] own_addr  = '0;
    logic [AddrW-1:0] coord_addr = '0;

    int err_count     = 0;
    int items_sent    = 0;
    int frames_built  = 0;
    int dropped_items = 0;
    int bytes_seen    = 0;
    int idle_cycles   = 0;
    int addr_settings = 1;  // reset values count as the first setting
    int random_items  = 0;

    int src_gap = 0, src_calm = 0;
    int sink_stall = 0, sink_calm = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none or short, a few long; now and then a calm
    // stretch with no idling at all.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(30, 150);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch on %s: got %02h, want %02h", $time, what, got, want);
        err_count++;
    endtask

    // reflected CRC-32 over one byte
    function automatic logic [31:0] crc_after(logic [31:0] c, logic [7:0] b);
        c ^= {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        t_out e;
        e.data = b;
        e.last = 1'b0;
        frame_bytes_due.push_back(e);
        run_crc = crc_after(run_crc, b);
    endtask

    task automatic put_addr(input logic [AddrW-1:0] a);
        for (int i = 5; i >= 0; i--) begin
            put_byte(a[8*i +: 8]);
        end
    endtask

    task automatic put_header(input logic [15:0] fc);
        run_crc = CrcInit;
        put_byte(fc[7:0]);
        put_byte(fc[15:8]);
        put_byte(8'h00);      // duration
        put_byte(8'h00);
        put_addr(coord_addr); // receiver
        put_addr(own_addr);   // transmitter
        put_addr(coord_addr); // BSS
        put_byte(8'h00);      // sequence control
        put_byte(8'h00);
    endtask

    // FCS is the inverted CRC, low byte first; tlast on the final byte
    task automatic put_fcs();
        logic [31:0] f;
        t_out        e;
        f = ~run_crc;
        for (int i = 0; i < 4; i++) begin
            e.data = f[8*i +: 8];
            e.last = (i == 3);
            frame_bytes_due.push_back(e);
        end
        frames_built++;
    endtask

    // Frame predictor: appends the bytes one accepted item causes.
    task automatic build_frame_bytes(input t_item it);
        if (!msg_open) begin
            // protocol frame: complete by itself, tlast on the item is ignored
            if (it.act == ACT_CSMA || it.act == ACT_TDMA) begin
                put_header(FcProt);
                put_byte((it.act == ACT_TDMA) ? 8'h01 : 8'h00);
                put_fcs();
                return;
            end
            // oversized metrics message: swallow up to its last item
            if (it.len > MaxPayload) begin
                msg_open = !it.fin;
                msg_drop = msg_open;
                dropped_items++;
                return;
            end
            put_header(FcMetr);
            msg_open = 1'b1;
            msg_drop = 1'b0;
        end else if (msg_drop) begin
            if (it.fin) begin
                msg_open = 1'b0;
                msg_drop = 1'b0;
            end
            dropped_items++;
            return;
        end
        // inside a message every item is payload; a zero length sends no byte
        if (it.len != '0) put_byte(it.data);
        if (it.fin) begin
            put_fcs();
            msg_open = 1'b0;
        end
    endtask

    task automatic push_item(input t_action act, input logic [7:0] data,
                             input logic [LenW-1:0] len, input logic fin);
        t_item it;
        it.act  = act;
        it.data = data;
        it.len  = len;
        it.fin  = fin;
        pending_items.push_back(it);
    endtask

    // One random message. Mostly well-formed metrics messages; the rest are
    // protocol frames, oversized messages and messages with odd lengths.
    task automatic add_random_message();
        int      r, n;
        t_action a0;
        logic [LenW-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            push_item($urandom_range(0, 1) ? ACT_TDMA : ACT_CSMA,
                      8'($urandom_range(0, 255)),
                      LenW'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
            random_items++;
        end else if (r < 27) begin
            // oversized: dropped whole, actions inside do not matter
            n   = $urandom_range(1, 6);
            len = LenW'($urandom_range(MaxPayload + 1, 4095));
            a0  = $urandom_range(0, 1) ? ACT_RSVD : ACT_METRICS;
            push_item(a0, 8'($urandom_range(0, 255)), len, n == 1);
            for (int i = 1; i < n; i++) begin
                push_item(t_action'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          LenW'($urandom_range(0, 4095)), i == n - 1);
            end
        end else if (r < 37) begin
            // length field unrelated to the item count, zero lengths scattered
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                len = ($urandom_range(0, 3) == 0) ? '0
                                                  : LenW'($urandom_range(0, MaxPayload));
                push_item((i == 0) ? ACT_METRICS : t_action'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), len, i == n - 1);
            end
            random_items += n;
        end else begin
            n  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            a0 = ($urandom_range(0, 7) == 0) ? ACT_RSVD : ACT_METRICS;
            for (int i = 0; i < n; i++) begin
                push_item((i == 0) ? a0 :
                          (($urandom_range(0, 9) == 0) ? t_action'($urandom_range(0, 3))
                                                        : ACT_METRICS),
                          8'($urandom_range(0, 255)), LenW'(n), i == n - 1);
            end
            random_items += n;
        end
    endtask

    task automatic fill_random(input int count);
        int stop_at;
        stop_at = random_items + count;
        while (random_items < stop_at) add_random_message();
    endtask

    // Wait for the stream side to drain and all predicted bytes to arrive,
    // then let SettleCycles pass for items that produce nothing.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || s_valid || frame_bytes_due.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; lands on the edge that sees
    // psel, penable and pready high.
    task automatic write_addr_reg(input logic sel, input logic [ApbDataW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ApbAddrW'(sel) << RegSelBit;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == RegOwn) own_addr = value[AddrW-1:0];
        else               coord_addr = value[AddrW-1:0];
    endtask

    // ------------------------------------------------------------------------
    // Stream driver: one transfer per item, random gaps between items.
    // The predictor runs on the edge the transfer completes.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                build_frame_bytes(cur_item);
                items_sent++;
            end
            // slot is free unless an item is still waiting for tready
            if (!(s_valid && !o_s_axis_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= {4'h0, cur_item.len, cur_item.data};
                    s_user  <= cur_item.act;
                    s_last  <= cur_item.fin;
                    src_gap = pick_gap(src_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink: random stalls, plus one long hold-off once traffic is under way so
    // the block backs up and throttles its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && bytes_seen >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
            m_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            sink_stall = pick_gap(sink_calm);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every output transfer is checked against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            bytes_seen++;
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("byte with nothing due", o_m_axis_tdata, 8'h00);
            end else begin
                e = frame_bytes_due.pop_front();
                if (o_m_axis_tdata !== e.data)
                    report_mismatch("frame byte", o_m_axis_tdata, e.data);
                if (o_m_axis_tlast !== e.last)
                    report_mismatch("tlast", {7'h0, o_m_axis_tlast}, {7'h0, e.last});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which no transfer of any kind happens
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IdleLimit) @(posedge i_clk);
        $display("watchdog: no transfer for %0d cycles, %0d bytes still due",
                 IdleLimit, frame_bytes_due.size());
        $display("tb_mac_frame_builder_crc32: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sweep at reset addresses (all zero).
        push_item(ACT_CSMA,    8'h00, 12'd0,    1'b0);  // protocol frame, tlast low
        push_item(ACT_TDMA,    8'hFF, 12'hFFF,  1'b1);  // junk fields ignored
        push_item(ACT_METRICS, 8'hAA, 12'd0,    1'b1);  // empty message: header + FCS
        push_item(ACT_METRICS, 8'hFF, 12'd1,    1'b1);  // one-byte message
        // inside a message the action is ignored; length 3 but 4 items
        push_item(ACT_METRICS, 8'h00, 12'd3,    1'b0);
        push_item(ACT_RSVD,    8'hFF, 12'd3,    1'b0);
        push_item(ACT_CSMA,    8'h5A, 12'd3,    1'b0);
        push_item(ACT_TDMA,    8'hA5, 12'd3,    1'b1);
        // oversized: whole message dropped
        push_item(ACT_METRICS, 8'h11, 12'hFFF,  1'b0);
        push_item(ACT_CSMA,    8'h22, 12'hFFF,  1'b0);
        push_item(ACT_METRICS, 8'h33, 12'hFFF,  1'b1);
        push_item(ACT_RSVD,    8'h44, 12'd1501, 1'b1);  // just over the limit, single item
        push_item(ACT_METRICS, 8'h55, 12'd1500, 1'b0);  // exactly at the limit
        push_item(ACT_METRICS, 8'h66, 12'd1500, 1'b1);
        push_item(ACT_RSVD,    8'h77, 12'd2,    1'b0);  // undefined action starts metrics
        push_item(ACT_METRICS, 8'h88, 12'd2,    1'b1);
        push_item(ACT_METRICS, 8'h99, 12'd5,    1'b0);  // zero length mid-message
        push_item(ACT_METRICS, 8'hCC, 12'd0,    1'b0);
        push_item(ACT_METRICS, 8'hDD, 12'd5,    1'b1);
        push_item(ACT_METRICS, 8'hEE, 12'd0,    1'b0);  // empty first item, then a byte
        push_item(ACT_METRICS, 8'h0F, 12'd1,    1'b1);
        push_item(ACT_TDMA,    8'h00, 12'd0,    1'b0);
        wait_idle();

        // Own address all ones, coordinator zero.
        write_addr_reg(RegOwn,   {16'h0000, 48'hFFFF_FFFF_FFFF});
        write_addr_reg(RegCoord, '0);
        addr_settings++;
        fill_random(PhaseItems);
        wait_idle();

        // Swapped extremes; this phase stops inside an open message.
        write_addr_reg(RegOwn,   '0);
        write_addr_reg(RegCoord, {16'h0000, 48'hFFFF_FFFF_FFFF});
        addr_settings++;
        fill_random(PhaseItems);
        push_item(ACT_METRICS, 8'h3C, 12'd6, 1'b0);
        push_item(ACT_METRICS, 8'hC3, 12'd6, 1'b0);
        wait_idle();

        // Random addresses written mid-message (upper data bits are junk);
        // they must only show up in the next header.
        write_addr_reg(RegOwn,   {$urandom, $urandom});
        write_addr_reg(RegCoord, {$urandom, $urandom});
        addr_settings++;
        for (int i = 0; i < 4; i++) begin
            push_item(ACT_METRICS, 8'($urandom_range(0, 255)), 12'd6, i == 3);
        end
        fill_random(PhaseItems);
        wait_idle();

        write_addr_reg(RegCoord, {$urandom, $urandom});
        write_addr_reg(RegOwn,   {$urandom, $urandom});
        addr_settings++;
        fill_random(PhaseItems);
        wait_idle();

        $display("covered %0d items (%0d dropped) under %0d address settings",
                 items_sent, dropped_items, addr_settings);
        $display("checked %0d frames, %0d bytes, with one %0d-cycle sink hold-off",
                 frames_built, bytes_seen, HoldCycles);
        if (err_count == 0) begin
            $display("tb_mac_frame_builder_crc32: PASS");
        end else begin
            $display("%0d mismatches", err_count);
            $display("tb_mac_frame_builder_crc32: FAIL");
        end
        $finish;
    end

endmodule
